@@ rtl/core/bfm3_pkg.sv @@
// ----------------------------------------------------------------------------
// Bloom filter package
// Shared constants and the payload types of the Bloom filter channels.
// ----------------------------------------------------------------------------
package bfm3_pkg;

    localparam int unsigned MaxBits   = 65536;
    localparam int unsigned AddrW     = $clog2(MaxBits);
    localparam int unsigned SizeW     = 17;
    localparam int unsigned KeyW      = 64;
    localparam int unsigned NumWords  = 4;

    localparam logic [63:0] HashSeed  = 64'd1;
    localparam logic [63:0] KeyBytes  = 64'd8;
    localparam logic [63:0] C1        = 64'h87c37b91114253d5;
    localparam logic [63:0] C2        = 64'h4cf5ad432745937f;
    localparam logic [63:0] Fmix1     = 64'hff51afd7ed558ccd;
    localparam logic [63:0] Fmix2     = 64'hc4ceb9fe1a85ec53;

    localparam logic OpInsert = 1'b0;
    localparam logic OpSearch = 1'b1;

    typedef struct packed {
        logic            op;
        logic [KeyW-1:0] key;
    } t_req;

    typedef struct packed {
        logic found;
    } t_rsp;

endpackage

@@ rtl/core/bfm3_if.sv @@
// ----------------------------------------------------------------------------
// Bloom filter channels
// Valid/ready channel interfaces for requests, responses and configuration.
// ----------------------------------------------------------------------------
interface bfm3_req_if;
    logic          valid;
    logic          ready;
    bfm3_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bfm3_rsp_if;
    logic          valid;
    logic          ready;
    bfm3_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bfm3_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bfm3_pkg::SizeW-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/bloom_filter_murmur3_insert_search_top.sv @@
// ----------------------------------------------------------------------------
// Bloom filter with MurmurHash3 x64_128
// Insert and search of 64-bit keys in a 64K-bit store.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the bit store, one word of
// 64 bits a cycle, while no request is taken. One shared 32x32 multiplier
// computes the six 64-bit products of the hash as four partial products each,
// with the mixing steps between them. A shared bit-serial remainder unit
// loads each of the four hash words and reduces it by the table size. Each
// reduced index is then read from the single-port store in a read step and
// tested in a check step, and the check step also writes the bit for an
// insert. A last step raises the response. The response sits in an output
// register until it is transferred; the next request is taken after that.
module bloom_filter_murmur3_insert_search_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bfm3_req_if.sink      i_req,
    bfm3_rsp_if.source    o_rsp,
    bfm3_cfg_if.sink      i_cfg
);

    localparam int unsigned WordW  = 64;
    localparam int unsigned RowW   = bfm3_pkg::AddrW - 6;
    localparam int unsigned Rows   = bfm3_pkg::MaxBits / WordW;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_K1M, S_K1R, S_K2M, S_MIX,
        S_F1A, S_F1M, S_F1B, S_F1N, S_F1C,
        S_F2A, S_F2M, S_F2B, S_F2N, S_F2C,
        S_FIN, S_MOD, S_RD, S_RDW, S_CHK, S_DONE
    } t_state;

    t_state r_state;
    logic [bfm3_pkg::SizeW-1:0] r_size;
    logic [RowW-1:0]  r_clr;
    logic             r_op;
    logic [63:0]      r_h1, r_h2;
    logic [63:0]      r_ma, r_mb, r_acc;
    logic [1:0]       r_pp;
    logic [1:0]       r_widx;
    logic [31:0]      r_num;
    logic [bfm3_pkg::SizeW-1:0] r_rem;
    logic [5:0]       r_bit;
    logic             r_found;
    logic             r_ovalid;
    logic [bfm3_pkg::AddrW-1:0] r_idx;
    logic [WordW-1:0] r_rdata;
    logic [WordW-1:0] mem [Rows];

    // Shared multiplier: one 32x32 partial product a cycle, low 64 bits kept.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p, pp_sh;
    always_comb begin
        mul_a = r_pp[0] ? r_ma[63:32] : r_ma[31:0];
        mul_b = r_pp[1] ? r_mb[63:32] : r_mb[31:0];
        mul_p = mul_a * mul_b;
        unique case (r_pp)
            2'd0:    pp_sh = mul_p;
            2'd1,
            2'd2:    pp_sh = {mul_p[31:0], 32'd0};
            default: pp_sh = 64'd0;
        endcase
    end
    wire [63:0] acc_n = r_acc + pp_sh;

    // Effective size: zero reads as one; sizes above the store are clamped to it.
    logic [bfm3_pkg::SizeW-1:0] eff;
    always_comb begin
        eff = r_size;
        if (r_size == '0) eff = bfm3_pkg::SizeW'(1);
        if (r_size > bfm3_pkg::SizeW'(bfm3_pkg::MaxBits))
            eff = bfm3_pkg::SizeW'(bfm3_pkg::MaxBits);
    end

    logic [bfm3_pkg::SizeW:0] rem_sh;
    logic [31:0] hword;
    always_comb begin
        rem_sh = {r_rem, r_num[31]};
        unique case (r_widx)
            2'd0: hword = r_h1[31:0];
            2'd1: hword = r_h1[63:32];
            2'd2: hword = r_h2[31:0];
            default: hword = r_h2[63:32];
        endcase
    end
    wire [bfm3_pkg::SizeW:0] rem_try = rem_sh - {1'b0, eff};

    wire [RowW-1:0] row = r_idx[bfm3_pkg::AddrW-1:6];
    wire [5:0]      col = r_idx[5:0];

    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data.found = r_found;

    // Store port: clearing writes, index reads and insert writes.
    // The read takes its row straight from the finished remainder.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem[r_clr] <= '0;
        end else if (r_state == S_CHK && r_op == bfm3_pkg::OpInsert) begin
            mem[row] <= r_rdata | (WordW'(1) << col);
        end
        if (r_state == S_RD) r_rdata <= mem[r_rem[bfm3_pkg::AddrW-1:6]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_size   <= bfm3_pkg::SizeW'(bfm3_pkg::MaxBits);
            r_ovalid <= 1'b0;
            r_pp     <= '0;
            r_widx   <= '0;
            r_found  <= 1'b0;
        end else begin
            if (i_cfg.valid) r_size <= i_cfg.data;
            if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + RowW'(1);
                    if (r_clr == RowW'(Rows - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_op  <= i_req.data.op;
                        r_ma  <= i_req.data.key;
                        r_mb  <= bfm3_pkg::C1;
                        r_acc <= '0;
                        r_pp  <= '0;
                        r_state <= S_K1M;
                    end
                end
                S_K1M, S_K2M, S_F1M, S_F1N, S_F2M, S_F2N: begin
                    r_acc <= acc_n;
                    r_pp  <= r_pp + 2'd1;
                    if (r_pp == 2'd3) begin
                        unique case (r_state)
                            S_K1M: r_state <= S_K1R;
                            S_K2M: r_state <= S_MIX;
                            S_F1M: r_state <= S_F1B;
                            S_F1N: r_state <= S_F1C;
                            S_F2M: r_state <= S_F2B;
                            default: r_state <= S_F2C;
                        endcase
                    end
                end
                S_K1R: begin
                    r_ma <= {r_acc[32:0], r_acc[63:33]};
                    r_mb <= bfm3_pkg::C2;
                    r_acc <= '0;
                    r_state <= S_K2M;
                end
                S_MIX: begin
                    // h1 = seed ^ k1 ^ len; h2 = seed ^ len; h1 += h2; h2 += h1.
                    r_h1 <= (bfm3_pkg::HashSeed ^ r_acc ^ bfm3_pkg::KeyBytes)
                          + (bfm3_pkg::HashSeed ^ bfm3_pkg::KeyBytes);
                    r_h2 <= (bfm3_pkg::HashSeed ^ r_acc ^ bfm3_pkg::KeyBytes)
                          + ((bfm3_pkg::HashSeed ^ bfm3_pkg::KeyBytes) << 1);
                    r_state <= S_F1A;
                end
                S_F1A, S_F2A: begin
                    r_ma  <= ((r_state == S_F1A) ? r_h1 : r_h2)
                           ^ (((r_state == S_F1A) ? r_h1 : r_h2) >> 33);
                    r_mb  <= bfm3_pkg::Fmix1;
                    r_acc <= '0;
                    r_state <= (r_state == S_F1A) ? S_F1M : S_F2M;
                end
                S_F1B, S_F2B: begin
                    r_ma  <= r_acc ^ (r_acc >> 33);
                    r_mb  <= bfm3_pkg::Fmix2;
                    r_acc <= '0;
                    r_state <= (r_state == S_F1B) ? S_F1N : S_F2N;
                end
                S_F1C: begin
                    r_h1 <= r_acc ^ (r_acc >> 33);
                    r_state <= S_F2A;
                end
                S_F2C: begin
                    r_h2 <= r_acc ^ (r_acc >> 33);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_h1 <= r_h1 + r_h2;
                    r_h2 <= r_h2 + r_h1 + r_h2;
                    r_widx <= '0;
                    r_found <= (r_op == bfm3_pkg::OpSearch);
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    // Load the next hash word into the remainder unit.
                    r_num <= hword;
                    r_rem <= '0;
                    r_bit <= '0;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    // Restoring remainder, one dividend bit a cycle.
                    r_num <= {r_num[30:0], 1'b0};
                    r_bit <= r_bit + 6'd1;
                    if (!rem_try[bfm3_pkg::SizeW]) r_rem <= rem_try[bfm3_pkg::SizeW-1:0];
                    else                           r_rem <= rem_sh[bfm3_pkg::SizeW-1:0];
                    if (r_bit == 6'd31) r_state <= S_RD;
                end
                S_RD: begin
                    r_idx <= r_rem[bfm3_pkg::AddrW-1:0];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_op == bfm3_pkg::OpSearch && !r_rdata[col]) r_found <= 1'b0;
                    r_widx <= r_widx + 2'd1;
                    r_state <= (r_widx == 2'd3) ? S_DONE : S_RDW;
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/core/bfm3_checker.sv @@
// ----------------------------------------------------------------------------
// Bloom filter port checker
// Watches the top-level ports for handshake and ordering slips.
// ----------------------------------------------------------------------------
module bfm3_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic o_rsp_valid,
    input logic o_rsp_ready,
    input logic o_found
);

    // A response stays offered until it is transferred.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid) else $error("rsp dropped");

    // The offered response does not change while it waits.
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> $stable(o_found)) else $error("rsp changed");

    // No request is taken while a response is still waiting.
    a_noreq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !i_req_ready) else $error("req taken over rsp");

    // A request is not followed by a response in the next cycle.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !o_rsp_valid) else $error("rsp too early");

    // No response while the block is ready for a new request.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_ready |-> !o_rsp_valid) else $error("ready with rsp");

endmodule

bind bloom_filter_murmur3_insert_search_top bfm3_checker u_bfm3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .o_rsp_valid (o_rsp.valid),
    .o_rsp_ready (o_rsp.ready),
    .o_found     (o_rsp.data.found)
);
